// ===== hdl/stb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants of the soft timer bank
// Sizes, action and event codes, controller states and the tick arithmetic.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int          SLOTS       = 4;
  localparam int          TICK_BITS   = 16;
  localparam int unsigned DELAY_LIMIT = 32767;

  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [SLOT_W-1:0]    slot_idx_t;
  typedef logic [SLOTS-1:0]     slot_mask_t;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_START  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_ANSWER = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    EV_START     = 2'd0,
    EV_ACK       = 2'd1,
    EV_EXPIRED   = 2'd2,
    EV_TICK_DONE = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLY,
    ST_SCAN,
    ST_TICK_DONE
  } state_t;

  // Write port of the expiry memory.
  typedef struct packed {
    logic      en;
    slot_idx_t addr;
    tick_t     data;
  } mem_wr_t;

  // Expiry time: tick plus the delay clamped to the largest delay.
  function automatic tick_t arm_time(tick_t tick, logic [15:0] delay);
    logic [31:0]           d;
    logic [TICK_BITS+31:0] s;
    d = ({16'b0, delay} > 32'(DELAY_LIMIT)) ? 32'(DELAY_LIMIT) : {16'b0, delay};
    s = {32'b0, tick} + {{TICK_BITS{1'b0}}, d};
    return s[TICK_BITS-1:0];
  endfunction

  // True when the wrap-around distance from expiry to now is within the limit.
  function automatic logic is_due(tick_t now, tick_t expiry);
    tick_t diff;
    diff = now - expiry;
    return ({32'b0, diff} <= {{TICK_BITS{1'b0}}, 32'(DELAY_LIMIT)});
  endfunction

  function automatic logic [15:0] tick_lo(tick_t t);
    logic [TICK_BITS+15:0] w;
    w = {16'b0, t};
    return w[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/stb_expiry_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stb_expiry_ram: expiry time store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stb_expiry_ram
  import stb_pkg::*;
(
  input  wire logic      clk,
  input  wire mem_wr_t   wr,
  input  wire slot_idx_t rd_addr,
  output logic [TICK_BITS-1:0] rd_data
);

  tick_t mem [SLOTS];
  tick_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hdl/soft_timer_bank_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soft_timer_bank_core: bank of one-shot / periodic software timer slots
// Tick, start, clear and answer words drive a small slot table whose expiry
// times live in a synchronous memory.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Ports                      Word
//   in_      slave      tvalid tready tdata tuser  one command (tuser = action)
//   out_     master     tvalid tready tdata tuser  one event (tuser = kind)
//            tlast      marks the final event caused by a command
//
// A start, clear or answer word is decoded into the pending reply, which is
// loaded into the output register once the output is free.
// A tick word is decoded, then walks the slots through the memory read port,
// one slot per cycle unless a due slot meets a stalled output, then sends the
// tick-done event.
// A stalled output holds the walk on the current slot when it is due; a new word is taken
// only when the controller is idle, while the last event may still wait.
// Reset (rst_n low, synchronous) clears the counter, the armed and waiting
// masks and the controller; the expiry memory is not cleared, since a slot
// is only read while armed and arming always writes its entry first.
// ----------------------------------------------------------------------------
module soft_timer_bank_core
  import stb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] delay, [19:16] slot_id
  input  wire logic [1:0]             in_tuser,   // [1:0] action
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [3:0] slot_id_out, [4] status,
                                                  // [20:5] tick_now
  output logic [1:0]                  out_tuser,  // [1:0] event_kind
  output logic                        out_tlast   // last
);

  localparam slot_idx_t LAST_SLOT = SLOT_W'(SLOTS - 1);

  // Control state.
  state_t     state_r,    state_nxt;
  tick_t      tick_r,     tick_nxt;
  slot_mask_t armed_r,    armed_nxt;
  slot_mask_t waiting_r,  waiting_nxt;
  slot_idx_t  scan_idx_r, scan_idx_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;

  // Pending reply of a single-result command, and the output register.
  event_t      res_kind_r,   res_kind_nxt;
  logic [3:0]  res_slot_r,   res_slot_nxt;
  logic        res_status_r, res_status_nxt;
  event_t      out_kind_r,   out_kind_nxt;
  logic [3:0]  out_slot_r,   out_slot_nxt;
  logic        out_status_r, out_status_nxt;
  logic [15:0] out_tick_r,   out_tick_nxt;
  logic        out_last_r,   out_last_nxt;

  // Memory ports.
  mem_wr_t   mem_wr;
  slot_idx_t mem_rd_addr;
  tick_t     mem_rd_data;

  // Input word fields.
  action_t     in_action;
  logic [15:0] in_delay;
  logic [3:0]  in_slot_id;
  logic        in_accept;
  logic        out_free;

  // Decode helpers.
  logic      free_found;
  slot_idx_t free_idx;
  logic      sid_valid;
  slot_idx_t sid_idx;
  logic      scan_hit;
  logic      scan_adv;

  assign in_action  = action_t'(in_tuser);
  assign in_delay   = in_tdata[15:0];
  assign in_slot_id = in_tdata[19:16];
  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;

  // The output register can take a new event when empty or being drained.
  assign out_free = !out_tvalid_r || out_tready;

  // Lowest free slot for a start command.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!armed_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign sid_valid = (in_slot_id != 4'd0) && (in_slot_id <= 4'(SLOTS));
  assign sid_idx   = SLOT_W'(in_slot_id - 4'd1);

  // A slot is reported when armed, not already waiting and due.
  assign scan_hit = armed_r[scan_idx_r] && !waiting_r[scan_idx_r]
                    && is_due(tick_r, mem_rd_data);
  assign scan_adv = !scan_hit || out_free;

  stb_expiry_ram u_expiry_ram (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_action == ACT_TICK) ? ST_SCAN : ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_adv && (scan_idx_r == LAST_SLOT)) begin
          state_nxt = ST_TICK_DONE;
        end
      end
      ST_TICK_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs per state.
  always_comb begin
    tick_nxt       = tick_r;
    armed_nxt      = armed_r;
    waiting_nxt    = waiting_r;
    scan_idx_nxt   = scan_idx_r;
    res_kind_nxt   = res_kind_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_tick_nxt   = out_tick_r;
    out_last_nxt   = out_last_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mem_wr         = '0;
    mem_rd_addr    = scan_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          res_kind_nxt   = EV_ACK;
          res_slot_nxt   = 4'd0;
          res_status_nxt = 1'b1;
          case (in_action)
            ACT_TICK: begin
              // Advance the counter and start the walk at the first slot.
              tick_nxt     = tick_r + tick_t'(1);
              scan_idx_nxt = '0;
              mem_rd_addr  = '0;
            end
            ACT_START: begin
              res_kind_nxt = EV_START;
              if (free_found) begin
                mem_wr.en              = 1'b1;
                mem_wr.addr            = free_idx;
                mem_wr.data            = arm_time(tick_r, in_delay);
                armed_nxt[free_idx]    = 1'b1;
                waiting_nxt[free_idx]  = 1'b0;
                res_slot_nxt           = 4'(free_idx) + 4'd1;
                res_status_nxt         = 1'b0;
              end
            end
            ACT_CLEAR: begin
              // Clearing an idle slot is allowed and acknowledged as ok.
              if (sid_valid) begin
                armed_nxt[sid_idx]   = 1'b0;
                waiting_nxt[sid_idx] = 1'b0;
                res_slot_nxt         = in_slot_id;
                res_status_nxt       = 1'b0;
              end
            end
            ACT_ANSWER: begin
              // Only a slot that awaits an answer takes one; a zero reload
              // stops it, anything else re-arms it from the current tick.
              if (sid_valid && waiting_r[sid_idx]) begin
                waiting_nxt[sid_idx] = 1'b0;
                if (in_delay == 16'd0) begin
                  armed_nxt[sid_idx] = 1'b0;
                end else begin
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = sid_idx;
                  mem_wr.data = arm_time(tick_r, in_delay);
                end
                res_slot_nxt   = in_slot_id;
                res_status_nxt = 1'b0;
              end
            end
            default: begin
              res_kind_nxt = EV_ACK;
            end
          endcase
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_kind_nxt   = res_kind_r;
          out_slot_nxt   = res_slot_r;
          out_status_nxt = res_status_r;
          out_tick_nxt   = tick_lo(tick_r);
          out_last_nxt   = 1'b1;
        end
      end
      ST_SCAN: begin
        // The read data belongs to scan_idx_r; a stall re-reads the same slot.
        if (scan_hit && out_free) begin
          out_tvalid_nxt         = 1'b1;
          out_kind_nxt           = EV_EXPIRED;
          out_slot_nxt           = 4'(scan_idx_r) + 4'd1;
          out_status_nxt         = 1'b0;
          out_tick_nxt           = tick_lo(tick_r);
          out_last_nxt           = 1'b0;
          waiting_nxt[scan_idx_r] = 1'b1;
        end
        if (scan_adv && (scan_idx_r != LAST_SLOT)) begin
          scan_idx_nxt = scan_idx_r + slot_idx_t'(1);
          mem_rd_addr  = scan_idx_r + slot_idx_t'(1);
        end
      end
      ST_TICK_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_kind_nxt   = EV_TICK_DONE;
          out_slot_nxt   = 4'd0;
          out_status_nxt = 1'b0;
          out_tick_nxt   = tick_lo(tick_r);
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
        out_tvalid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_r       <= '0;
      armed_r      <= '0;
      waiting_r    <= '0;
      scan_idx_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_r       <= tick_nxt;
      armed_r      <= armed_nxt;
      waiting_r    <= waiting_nxt;
      scan_idx_r   <= scan_idx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_kind_r   <= res_kind_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    out_kind_r   <= out_kind_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_tick_r   <= out_tick_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_tick_r, out_status_r, out_slot_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
